FILE: rtl/fpq88_pkg.sv
// Shared types and constants for the Q8.8 fixed-point ALU.
package fpq88_pkg;

    localparam int DEF_FRACTION_BITS = 8;
    localparam int DATA_W = 16;
    localparam int EXACT_W = 34;
    localparam int PROD_W = 32;
    localparam int MAG_W = 17;

    typedef enum logic [2:0] {
        OP_ABS  = 3'd0,
        OP_RND  = 3'd1,
        OP_MUL  = 3'd2,
        OP_RMUL = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5,
        OP_RSV6 = 3'd6,
        OP_RSV7 = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // Side data carried alongside the divider stages
    typedef struct packed {
        logic                       valid;
        t_op                        op;
        logic                       a_neg;
        logic signed [DATA_W-1:0]   b;
        logic [MAG_W-1:0]           bmag;
        logic signed [EXACT_W-1:0]  exact;
        logic signed [PROD_W-1:0]   prod;
    } t_side;

endpackage

FILE: rtl/fixed_point_q8_8_alu_core.sv
// Pipelined signed fixed-point ALU with a one-bit-per-stage divider.
// Stages in order: input register, setup, divider chain, output register.
// Throughput: one request per cycle; the whole pipe holds while the output waits.
// The divider path, one quotient bit per register stage, sets the depth.
// Reset (synchronous, active low) clears all valid bits; no clearing pass.
module fixed_point_q8_8_alu_core #(
    parameter int FRACTION_BITS = fpq88_pkg::DEF_FRACTION_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [2:0]                             i_operation,
    input  logic signed [fpq88_pkg::DATA_W-1:0]    i_operand_a,
    input  logic signed [fpq88_pkg::DATA_W-1:0]    i_operand_b,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [fpq88_pkg::DATA_W-1:0]    o_result_value,
    output logic [1:0]                             o_status
);
    import fpq88_pkg::*;

    localparam int DW = DATA_W + FRACTION_BITS;
    localparam int FB = FRACTION_BITS;

    logic w_adv;

    // input stage
    logic                       r_v;
    t_op                        r_op;
    logic signed [DATA_W-1:0]   r_a;
    logic signed [DATA_W-1:0]   r_b;

    // divider chain, index 0 is the setup stage output
    t_side              r_side [DW+1];
    logic [MAG_W-1:0]   r_rem  [DW+1];
    logic [DW-1:0]      r_nq   [DW+1];
    t_side              n_side [DW+1];
    logic [MAG_W-1:0]   n_rem  [DW+1];
    logic [DW-1:0]      n_nq   [DW+1];

    logic                       r_out_v;
    logic signed [DATA_W-1:0]   r_out_val;
    logic [1:0]                 r_out_st;
    logic signed [DATA_W-1:0]   n_out_val;
    logic [1:0]                 n_out_st;

    assign w_adv   = !r_out_v || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_v;
    assign o_result_value = r_out_val;
    assign o_status = r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
        if (w_adv) begin
            r_op <= t_op'(i_operation);
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
    end

    // setup: magnitudes, non-divide results, divider operands;
    // then restoring divide, one quotient bit per stage
    always_comb begin
        logic signed [MAG_W-1:0]    a_ext;
        logic signed [MAG_W-1:0]    b_ext;
        logic [MAG_W-1:0]           amag;
        logic [MAG_W-1:0]           bmag;
        logic signed [EXACT_W-1:0]  a_wide;
        logic signed [EXACT_W-1:0]  ip;
        logic [FB-1:0]              frac;
        logic                       up;
        logic [MAG_W-1:0]           rma;
        logic [EXACT_W-1:0]         rp;
        logic [MAG_W-1:0]           t;
        logic                       ge;
        a_ext = MAG_W'(r_a);
        b_ext = MAG_W'(r_b);
        amag  = r_a[DATA_W-1] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
        bmag  = r_b[DATA_W-1] ? MAG_W'(-b_ext) : MAG_W'(b_ext);
        a_wide = EXACT_W'(r_a);
        frac  = r_a[FB-1:0];
        // for negative operands the tie rounds down
        up = r_a[DATA_W-1] ? (frac > {1'b1, {(FB-1){1'b0}}})
                           : (frac >= {1'b1, {(FB-1){1'b0}}});
        ip = (a_wide >>> FB) + EXACT_W'(up);
        rma = amag >> FB;
        rp  = EXACT_W'(rma) * EXACT_W'(bmag[FB-1:0]);

        n_side[0].valid = r_v;
        n_side[0].op    = r_op;
        n_side[0].a_neg = r_a[DATA_W-1];
        n_side[0].b     = r_b;
        n_side[0].bmag  = bmag;
        n_side[0].prod  = PROD_W'(r_a) * PROD_W'(r_b);
        unique case (r_op)
            OP_ABS:  n_side[0].exact = EXACT_W'(amag);
            OP_RND:  n_side[0].exact = ip <<< FB;
            OP_RMUL: n_side[0].exact = (r_a[DATA_W-1] ^ r_b[DATA_W-1])
                                       ? -$signed(rp) : $signed(rp);
            default: n_side[0].exact = '0;
        endcase
        n_rem[0] = '0;
        n_nq[0]  = (r_op == OP_DIV) ? DW'(amag) << FB : DW'(amag);

        for (int k = 0; k < DW; k++) begin
            t  = {r_rem[k][MAG_W-2:0], r_nq[k][DW-1]};
            ge = (t >= r_side[k].bmag);
            n_side[k+1] = r_side[k];
            n_rem[k+1]  = ge ? t - r_side[k].bmag : t;
            n_nq[k+1]   = {r_nq[k][DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DW; k++) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (w_adv) begin
                r_side[k].valid <= n_side[k].valid;
            end
            if (w_adv) begin
                r_side[k].op    <= n_side[k].op;
                r_side[k].a_neg <= n_side[k].a_neg;
                r_side[k].b     <= n_side[k].b;
                r_side[k].bmag  <= n_side[k].bmag;
                r_side[k].exact <= n_side[k].exact;
                r_side[k].prod  <= n_side[k].prod;
                r_rem[k]        <= n_rem[k];
                r_nq[k]         <= n_nq[k];
            end
        end
    end

    // final stage: signs, truncation, overflow
    always_comb begin
        t_side                      s;
        logic signed [EXACT_W-1:0]  q;
        logic signed [EXACT_W-1:0]  rm;
        logic signed [EXACT_W-1:0]  pw;
        logic signed [EXACT_W-1:0]  ex;
        logic                       bz;
        logic                       ovf;
        s  = r_side[DW];
        q  = $signed(EXACT_W'(r_nq[DW]));
        rm = $signed(EXACT_W'(r_rem[DW]));
        pw = EXACT_W'(s.prod);
        bz = (s.b == '0);
        // truncate toward zero
        if (s.prod[PROD_W-1]) begin
            pw = pw + EXACT_W'((1 << FB) - 1);
        end
        unique case (s.op)
            OP_MUL:  ex = pw >>> FB;
            OP_DIV:  ex = (s.a_neg ^ s.b[DATA_W-1]) ? -q : q;
            OP_MOD:  ex = (s.a_neg && rm != '0) ? EXACT_W'(s.b) - rm : rm;
            OP_ABS, OP_RND, OP_RMUL: ex = s.exact;
            default: ex = '0;
        endcase
        ovf = !((&ex[EXACT_W-1:DATA_W-1]) || !(|ex[EXACT_W-1:DATA_W-1]));
        if ((s.op == OP_DIV || s.op == OP_MOD) && bz) begin
            n_out_val = '0;
            n_out_st  = ST_DIVZ;
        end else begin
            n_out_val = ex[DATA_W-1:0];
            n_out_st  = ovf ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_side[DW].valid;
        end
        if (w_adv) begin
            r_out_val <= n_out_val;
            r_out_st  <= n_out_st;
        end
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the Q8.8 fixed-point ALU core.
`timescale 1ns / 1ps

module testbench;
    import fpq88_pkg::*;

    localparam int LATENCY = 27;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_op              op;
        logic [15:0]      a;
        logic [15:0]      b;
    } t_request;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_operation = '0;
    logic signed [15:0] i_operand_a = '0;
    logic signed [15:0] i_operand_b = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_result_value;
    logic [1:0] o_status;

    t_request pending_q[$];
    t_answer  answer_q[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_sender = 1'b0;
    bit failed = 1'b0;
    int cycles = 0;

    fixed_point_q8_8_alu_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Exact result then wrap to 16 bits
    function automatic t_answer alu_result(t_request rq);
        longint a, b, r, f, ip, p;
        logic [1:0] st;
        t_answer ans;
        a = longint'($signed(rq.a));
        b = longint'($signed(rq.b));
        r = 0;
        st = ST_OK;
        case (rq.op)
            OP_ABS: r = a < 0 ? -a : a;
            OP_RND: begin
                f = a & 255;
                ip = (a - f) / 256;
                if (a >= 0 ? f >= 128 : f > 128) ip = ip + 1;
                r = ip * 256;
            end
            OP_MUL: r = (a * b) / 256;
            OP_RMUL: begin
                p = ((a < 0 ? -a : a) / 256) * ((b < 0 ? -b : b) & 255);
                r = ((a < 0) != (b < 0)) ? -p : p;
            end
            OP_DIV: begin
                if (b == 0) st = ST_DIVZ;
                else r = (a * 256) / b;
            end
            OP_MOD: begin
                if (b == 0) st = ST_DIVZ;
                else if (a != 0) begin
                    r = a % b;
                    if (r < 0) r = r + b;
                end
            end
            default: r = 0;
        endcase
        if (st == ST_OK && (r < -32768 || r > 32767)) st = ST_OVF;
        ans.value = r[15:0];
        ans.status = st;
        return ans;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        t_request rq;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_q.size() > 0 && !hold_sender &&
                        $urandom_range(99) >= send_idle_pct) begin
                    rq = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= rq.op;
                    i_operand_a <= rq.a;
                    i_operand_b <= rq.b;
                    answer_q.push_back(alu_result(rq));
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result value %h status %0d",
                         $time, o_result_value, o_status);
                failed = 1'b1;
            end else begin
                exp_ans = answer_q.pop_front();
                if (o_result_value !== exp_ans.value) begin
                    $display("%0t: value expected %h actual %h", $time,
                             exp_ans.value, o_result_value);
                    failed = 1'b1;
                end
                if (o_status !== exp_ans.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_ans.status, o_status);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL fixed_point_q8_8_alu_core");
            $finish;
        end
    end

    function automatic logic [15:0] edgy_operand();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'(1 << $urandom_range(15));
            5: return {8'($urandom), 8'h80};
            6: return 16'($signed(8'($urandom)));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_request(t_op op, logic [15:0] a, logic [15:0] b);
        t_request rq;
        rq.op = op;
        rq.a = a;
        rq.b = b;
        pending_q.push_back(rq);
    endtask

    task automatic add_random(int n);
        t_op op;
        for (int k = 0; k < n; k++) begin
            op = t_op'($urandom_range(7));
            add_request(op, $urandom_range(1) ? edgy_operand() : 16'($urandom),
                        $urandom_range(1) ? edgy_operand() : 16'($urandom));
        end
    endtask

    task automatic wait_drain();
        while (pending_q.size() > 0 || answer_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, the special cases
        add_request(OP_ABS, 16'h8000, 16'h0000);
        add_request(OP_ABS, 16'hff00, 16'h1234);
        add_request(OP_ABS, 16'h7fff, 16'hffff);
        add_request(OP_RND, 16'h0180, 16'h0000);
        add_request(OP_RND, 16'hfe80, 16'h0000);
        add_request(OP_RND, 16'hfe81, 16'h0000);
        add_request(OP_RND, 16'h7fff, 16'h0000);
        add_request(OP_RND, 16'h8000, 16'h0000);
        add_request(OP_MUL, 16'h8000, 16'h8000);
        add_request(OP_MUL, 16'h7fff, 16'h8000);
        add_request(OP_MUL, 16'hffff, 16'h0001);
        add_request(OP_RMUL, 16'h8000, 16'h80ff);
        add_request(OP_RMUL, 16'h7fff, 16'hffff);
        add_request(OP_DIV, 16'h1234, 16'h0000);
        add_request(OP_DIV, 16'h0000, 16'h0000);
        add_request(OP_DIV, 16'h8000, 16'hffff);
        add_request(OP_DIV, 16'h7fff, 16'h0001);
        add_request(OP_MOD, 16'h0000, 16'h0000);
        add_request(OP_MOD, 16'hfff3, 16'h0010);
        add_request(OP_MOD, 16'h8000, 16'hffff);
        add_request(OP_MOD, 16'h0005, 16'h8000);
        add_request(OP_MOD, 16'h0000, 16'h8000);
        add_request(OP_RSV6, 16'hffff, 16'hffff);
        add_request(OP_RSV7, 16'h8000, 16'h7fff);
        wait_drain();

        add_random(500);
        wait_drain();
        hold_sender = 1'b1;
        repeat (40) @(posedge i_clk);
        hold_sender = 1'b0;

        send_idle_pct = 60;
        add_random(450);
        wait_drain();

        send_idle_pct = 0;
        recv_stall_pct = 60;
        add_random(500);
        wait_drain();

        send_idle_pct = 16;
        recv_stall_pct = 16;
        add_random(500);
        wait_drain();

        repeat (LATENCY + 5) @(posedge i_clk);
        if (!failed && answer_q.size() == 0)
            $display("PASS fixed_point_q8_8_alu_core");
        else
            $display("FAIL fixed_point_q8_8_alu_core");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/fpq88_pkg.sv
rtl/fixed_point_q8_8_alu_core.sv
tb/testbench.sv
